// ===== rtl/mktd_pkg.sv =====
package mktd_pkg;

    localparam int MAX_SYMBOLS   = 7;
    localparam int TEXT_CAPACITY = 32;
    localparam int SEQ_LEN_W     = 3;
    localparam int SEQ_BITS_W    = 7;
    localparam int COUNT_W       = 6;
    localparam int CHAR_W        = 7;
    localparam int TIME_W        = 32;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 3;

    typedef logic [SEQ_LEN_W-1:0]  t_seq_len;
    typedef logic [SEQ_BITS_W-1:0] t_seq_bits;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [CHAR_W-1:0]     t_char;
    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [15:0]           t_ms16;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_DOT      = 3'd1,
        EV_DASH     = 3'd2,
        EV_CHAR     = 3'd3,
        EV_SPACE    = 3'd4,
        EV_REJECT   = 3'd5,
        EV_OVERFLOW = 3'd6,
        EV_NOSPACE  = 3'd7
    } t_event;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DOT_MAX    = 3'd0,
        CFG_DASH_MIN   = 3'd1,
        CFG_SYMBOL_GAP = 3'd2,
        CFG_WORD_GAP   = 3'd3,
        CFG_MAX_TEXT   = 3'd4
    } t_cfg_index;

    localparam t_ms16  DOT_MAX_RESET    = 16'd200;
    localparam t_ms16  DASH_MIN_RESET   = 16'd300;
    localparam t_ms16  SYMBOL_GAP_RESET = 16'd600;
    localparam t_ms16  WORD_GAP_RESET   = 16'd1400;
    localparam t_count MAX_TEXT_RESET   = 6'd32;
    localparam t_char  SPACE_CHAR       = 7'(" ");

    typedef struct packed {
        logic  key_press;
        logic  key_release;
        t_time now_ms;
        logic  clear_text;
    } t_poll;

    typedef struct packed {
        t_event    event_res;
        t_char     char_code;
        t_count    text_count;
        t_seq_len  pending_length;
        t_seq_bits pending_pattern;
    } t_result;

    // Symbol i of a sequence sits in bit i of the pattern, a dash is a one.
    function automatic t_char decode_char(input t_seq_len len, input t_seq_bits bits);
        t_char ch;
        ch = '0;
        unique case ({len, bits})
            {3'd2, 7'd2}:  ch = 7'("A");
            {3'd4, 7'd1}:  ch = 7'("B");
            {3'd4, 7'd5}:  ch = 7'("C");
            {3'd3, 7'd1}:  ch = 7'("D");
            {3'd1, 7'd0}:  ch = 7'("E");
            {3'd4, 7'd4}:  ch = 7'("F");
            {3'd3, 7'd3}:  ch = 7'("G");
            {3'd4, 7'd0}:  ch = 7'("H");
            {3'd2, 7'd0}:  ch = 7'("I");
            {3'd4, 7'd14}: ch = 7'("J");
            {3'd3, 7'd5}:  ch = 7'("K");
            {3'd4, 7'd2}:  ch = 7'("L");
            {3'd2, 7'd3}:  ch = 7'("M");
            {3'd2, 7'd1}:  ch = 7'("N");
            {3'd3, 7'd7}:  ch = 7'("O");
            {3'd4, 7'd6}:  ch = 7'("P");
            {3'd4, 7'd11}: ch = 7'("Q");
            {3'd3, 7'd2}:  ch = 7'("R");
            {3'd3, 7'd0}:  ch = 7'("S");
            {3'd1, 7'd1}:  ch = 7'("T");
            {3'd3, 7'd4}:  ch = 7'("U");
            {3'd4, 7'd8}:  ch = 7'("V");
            {3'd3, 7'd6}:  ch = 7'("W");
            {3'd4, 7'd9}:  ch = 7'("X");
            {3'd4, 7'd13}: ch = 7'("Y");
            {3'd4, 7'd3}:  ch = 7'("Z");
            {3'd5, 7'd31}: ch = 7'("0");
            {3'd5, 7'd30}: ch = 7'("1");
            {3'd5, 7'd28}: ch = 7'("2");
            {3'd5, 7'd24}: ch = 7'("3");
            {3'd5, 7'd16}: ch = 7'("4");
            {3'd5, 7'd0}:  ch = 7'("5");
            {3'd5, 7'd1}:  ch = 7'("6");
            {3'd5, 7'd3}:  ch = 7'("7");
            {3'd5, 7'd7}:  ch = 7'("8");
            {3'd5, 7'd15}: ch = 7'("9");
            {3'd6, 7'd42}: ch = 7'(".");
            {3'd6, 7'd51}: ch = 7'(",");
            {3'd6, 7'd12}: ch = 7'("?");
            {3'd6, 7'd30}: ch = 7'("'");
            {3'd6, 7'd53}: ch = 7'("!");
            {3'd5, 7'd9}:  ch = 7'("/");
            {3'd5, 7'd13}: ch = 7'("(");
            {3'd6, 7'd45}: ch = 7'(")");
            {3'd5, 7'd2}:  ch = 7'("&");
            {3'd6, 7'd7}:  ch = 7'(":");
            {3'd6, 7'd21}: ch = 7'(";");
            {3'd5, 7'd17}: ch = 7'("=");
            {3'd5, 7'd10}: ch = 7'("+");
            {3'd6, 7'd33}: ch = 7'("-");
            {3'd6, 7'd44}: ch = 7'("_");
            {3'd6, 7'd18}: ch = 7'("\"");
            {3'd6, 7'd22}: ch = 7'("@");
            {3'd7, 7'd72}: ch = 7'("$");
            {3'd5, 7'd22}: ch = 7'(">");
            {3'd5, 7'd26}: ch = 7'("<");
            default:       ch = '0;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/mktd_if.sv =====
interface mktd_poll_if;
    logic                 valid;
    logic                 ready;
    logic                 key_press;
    logic                 key_release;
    mktd_pkg::t_time      now_ms;
    logic                 clear_text;

    modport source (output valid, key_press, key_release, now_ms, clear_text, input ready);
    modport sink   (input valid, key_press, key_release, now_ms, clear_text, output ready);
endinterface

interface mktd_result_if;
    logic                 valid;
    logic                 ready;
    logic [2:0]           event_res;
    mktd_pkg::t_char      char_code;
    mktd_pkg::t_count     text_count;
    mktd_pkg::t_seq_len   pending_length;
    mktd_pkg::t_seq_bits  pending_pattern;

    modport source (output valid, event_res, char_code, text_count, pending_length,
                    pending_pattern, input ready);
    modport sink   (input valid, event_res, char_code, text_count, pending_length,
                    pending_pattern, output ready);
endinterface

interface mktd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [mktd_pkg::CFG_INDEX_W-1:0]     index;
    logic [mktd_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/morse_key_timing_decoder.sv =====
// Morse key timing decoder. Every key poll request gives exactly one result request. The block
// sustains one poll per clock cycle while the result side does not stall. A poll is first held in
// the input register; the step logic computes its result, which is held in the result register.
// The step logic is combinational, and its state feeds back into the next poll. Backpressure on
// the result side stalls the input register only once the result register is full. The user must
// write the timing thresholds and the text limit through the configuration channel only while no
// poll is in flight; the block itself does not enforce this. The configuration channel is always
// ready. Reset is synchronous and active low.
module morse_key_timing_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mktd_poll_if.sink            i_poll,
    mktd_result_if.source        o_result,
    mktd_cfg_if.sink             i_cfg
);

    mktd_pkg::t_ms16     r_dot_max;
    mktd_pkg::t_ms16     r_dash_min;
    mktd_pkg::t_ms16     r_symbol_gap;
    mktd_pkg::t_ms16     r_word_gap;
    mktd_pkg::t_count    r_max_text;

    logic                r_key_down;
    logic                r_space_done;
    mktd_pkg::t_time     r_press_start;
    mktd_pkg::t_time     r_last_activity;
    mktd_pkg::t_seq_len  r_seq_len;
    mktd_pkg::t_seq_bits r_seq_bits;
    mktd_pkg::t_count    r_char_count;

    logic                r_in_valid;
    mktd_pkg::t_poll     r_in;
    logic                r_out_valid;
    mktd_pkg::t_result   r_out;

    logic                n_key_down;
    logic                n_space_done;
    mktd_pkg::t_time     n_press_start;
    mktd_pkg::t_time     n_last_activity;
    mktd_pkg::t_seq_len  n_seq_len;
    mktd_pkg::t_seq_bits n_seq_bits;
    mktd_pkg::t_count    n_char_count;
    mktd_pkg::t_result   n_out;

    logic                advance;
    logic                in_ready;
    logic                cfg_write;
    mktd_pkg::t_count    text_limit;
    mktd_pkg::t_count    cfg_limit;

    assign advance   = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready  = !r_in_valid || advance;
    assign cfg_write = i_cfg.valid && i_cfg.ready;

    assign i_poll.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    assign text_limit = (r_max_text < mktd_pkg::COUNT_W'(mktd_pkg::TEXT_CAPACITY))
                        ? r_max_text : mktd_pkg::COUNT_W'(mktd_pkg::TEXT_CAPACITY);
    assign cfg_limit  = (i_cfg.data[mktd_pkg::COUNT_W-1:0]
                         < mktd_pkg::COUNT_W'(mktd_pkg::TEXT_CAPACITY))
                        ? i_cfg.data[mktd_pkg::COUNT_W-1:0]
                        : mktd_pkg::COUNT_W'(mktd_pkg::TEXT_CAPACITY);

    always_comb begin
        mktd_pkg::t_count    cnt0;
        mktd_pkg::t_time     held;
        mktd_pkg::t_time     idle;
        logic                dash;
        mktd_pkg::t_event    ev;
        mktd_pkg::t_char     ch;
        mktd_pkg::t_char     dec;

        cnt0            = r_in.clear_text ? '0 : r_char_count;
        n_seq_len       = r_in.clear_text ? '0 : r_seq_len;
        n_seq_bits      = r_in.clear_text ? '0 : r_seq_bits;
        n_key_down      = r_key_down;
        n_space_done    = r_space_done;
        n_press_start   = r_press_start;
        n_last_activity = r_last_activity;
        n_char_count    = cnt0;
        ev              = mktd_pkg::EV_NONE;
        ch              = '0;

        held = r_in.now_ms - r_press_start;
        dash = (held > mktd_pkg::TIME_W'(r_dot_max)) && (held >= mktd_pkg::TIME_W'(r_dash_min));

        if (!r_key_down && r_in.key_press) begin
            n_key_down      = 1'b1;
            n_press_start   = r_in.now_ms;
            n_last_activity = r_in.now_ms;
            n_space_done    = 1'b0;
        end else if (r_key_down && r_in.key_release) begin
            if (n_seq_len < mktd_pkg::SEQ_LEN_W'(mktd_pkg::MAX_SYMBOLS)) begin
                n_seq_bits = n_seq_bits | (mktd_pkg::SEQ_BITS_W'(dash) << n_seq_len);
                n_seq_len  = n_seq_len + 1'b1;
                ev         = dash ? mktd_pkg::EV_DASH : mktd_pkg::EV_DOT;
            end else begin
                n_seq_len  = '0;
                n_seq_bits = '0;
                ev         = mktd_pkg::EV_OVERFLOW;
            end
            n_key_down      = 1'b0;
            n_last_activity = r_in.now_ms;
        end

        idle = r_in.now_ms - n_last_activity;
        dec  = mktd_pkg::decode_char(n_seq_len, n_seq_bits);

        if (!n_key_down) begin
            if (n_seq_len != '0) begin
                if (idle >= mktd_pkg::TIME_W'(r_symbol_gap)) begin
                    ch = '0;
                    if (dec != '0 && cnt0 < text_limit) begin
                        n_char_count = cnt0 + 1'b1;
                        ev           = mktd_pkg::EV_CHAR;
                        ch           = dec;
                    end else begin
                        ev = mktd_pkg::EV_REJECT;
                    end
                    n_seq_len       = '0;
                    n_seq_bits      = '0;
                    n_last_activity = r_in.now_ms;
                end
            end else if (idle >= mktd_pkg::TIME_W'(r_word_gap)) begin
                if (cnt0 != '0 && !r_space_done) begin
                    if (cnt0 < text_limit) begin
                        n_char_count = cnt0 + 1'b1;
                        n_space_done = 1'b1;
                        ev           = mktd_pkg::EV_SPACE;
                        ch           = mktd_pkg::SPACE_CHAR;
                    end else begin
                        ev = mktd_pkg::EV_NOSPACE;
                        ch = '0;
                    end
                end
                n_last_activity = r_in.now_ms;
            end
        end

        n_out.event_res       = ev;
        n_out.char_code       = ch;
        n_out.text_count      = n_char_count;
        n_out.pending_length  = n_seq_len;
        n_out.pending_pattern = n_seq_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_max    <= mktd_pkg::DOT_MAX_RESET;
            r_dash_min   <= mktd_pkg::DASH_MIN_RESET;
            r_symbol_gap <= mktd_pkg::SYMBOL_GAP_RESET;
            r_word_gap   <= mktd_pkg::WORD_GAP_RESET;
            r_max_text   <= mktd_pkg::MAX_TEXT_RESET;
        end else if (cfg_write) begin
            unique case (i_cfg.index)
                mktd_pkg::CFG_DOT_MAX:    r_dot_max    <= i_cfg.data;
                mktd_pkg::CFG_DASH_MIN:   r_dash_min   <= i_cfg.data;
                mktd_pkg::CFG_SYMBOL_GAP: r_symbol_gap <= i_cfg.data;
                mktd_pkg::CFG_WORD_GAP:   r_word_gap   <= i_cfg.data;
                mktd_pkg::CFG_MAX_TEXT:   r_max_text   <= i_cfg.data[mktd_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_down      <= 1'b0;
            r_space_done    <= 1'b0;
            r_press_start   <= '0;
            r_last_activity <= '0;
            r_seq_len       <= '0;
            r_seq_bits      <= '0;
            r_char_count    <= '0;
        end else if (advance) begin
            r_key_down      <= n_key_down;
            r_space_done    <= n_space_done;
            r_press_start   <= n_press_start;
            r_last_activity <= n_last_activity;
            r_seq_len       <= n_seq_len;
            r_seq_bits      <= n_seq_bits;
            r_char_count    <= n_char_count;
        end else if (cfg_write && i_cfg.index == mktd_pkg::CFG_MAX_TEXT) begin
            // Lowering the limit below the current text length trims the text.
            if (r_char_count > cfg_limit) begin
                r_char_count <= cfg_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_poll.valid && in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_poll.valid && in_ready) begin
            r_in.key_press   <= i_poll.key_press;
            r_in.key_release <= i_poll.key_release;
            r_in.now_ms      <= i_poll.now_ms;
            r_in.clear_text  <= i_poll.clear_text;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.event_res       = r_out.event_res;
    assign o_result.char_code       = r_out.char_code;
    assign o_result.text_count      = r_out.text_count;
    assign o_result.pending_length  = r_out.pending_length;
    assign o_result.pending_pattern = r_out.pending_pattern;

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("Result register empty after a step.");

    a_input_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("Stalled poll dropped from the input register.");

    a_count_within_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_char_count <= mktd_pkg::COUNT_W'(mktd_pkg::TEXT_CAPACITY)))
        else $error("Text count beyond capacity.");

    a_space_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == mktd_pkg::EV_SPACE)
        |-> (r_out.char_code == mktd_pkg::SPACE_CHAR && r_out.text_count != '0))
        else $error("Space result with wrong character or empty text.");

    a_empty_sequence_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_seq_len == '0) |=> (r_seq_bits == '0))
        else $error("Pattern bits left behind an empty sequence.");

endmodule
